// ===== hw/rtl/cdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types, codes and helpers of the countdown timer with presets.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int SLOTS_DEF = 4;

  localparam int IN_W  = 8;   // in_tdata width
  localparam int USR_W = 8;   // in_tuser width
  localparam int RES_W = 22;  // packed result fields
  localparam int OUT_W = 24;  // out_tdata width

  localparam logic [15:0] PRESET_INIT_WORD = 16'h0100;
  localparam logic [6:0]  HIGH_MAX         = 7'd99;
  localparam logic [5:0]  LOW_MAX          = 6'd59;

  // event kinds
  localparam logic [1:0] OPC_INIT  = 2'd0;
  localparam logic [1:0] OPC_TICK  = 2'd1;
  localparam logic [1:0] OPC_SHORT = 2'd2;
  localparam logic [1:0] OPC_LONG  = 2'd3;

  // buttons
  localparam logic [1:0] BTN_UP   = 2'd0;
  localparam logic [1:0] BTN_DOWN = 2'd1;
  localparam logic [1:0] BTN_SEL  = 2'd2;
  localparam logic [1:0] BTN_BACK = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SAN,
    ST_INIT_LOAD,
    ST_TICK_CHK,
    ST_ROLL1,
    ST_ROLL2,
    ST_BACK_LOAD,
    ST_RESUME,
    ST_SCAN,
    ST_SHIFT,
    ST_FIN
  } ctl_state_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_SANITIZE,
    DP_INIT_LOAD,
    DP_TICK,
    DP_EXPIRE,
    DP_UNHANDLED,
    DP_EXIT_PLAY,
    DP_STEP_UP,
    DP_STEP_DOWN,
    DP_PAUSE,
    DP_ROLL1,
    DP_ROLL2,
    DP_BACK_LOAD,
    DP_TOGGLE_FOCUS,
    DP_TOGGLE_UNIT,
    DP_LEAVE,
    DP_START,
    DP_RESUME,
    DP_SCAN,
    DP_SHIFT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] button;
    logic       play;
    logic       paused;
    logic       save;
    logic       init_done;
    logic       zero;
    logic       roll_match;
    logic       scan_hit;
    logic       ptr_last;
  } dp_status_t;

  function automatic logic [6:0] sat_high(input logic [6:0] v);
    return (v > HIGH_MAX) ? HIGH_MAX : v;
  endfunction

  function automatic logic [5:0] sat_low(input logic [7:0] v);
    logic [5:0] r;
    r = (v > {2'b00, LOW_MAX}) ? LOW_MAX : v[5:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/cdt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_datapath
// Count fields, mode flags, preset store and result register.
// ----------------------------------------------------------------------------
module cdt_datapath #(
  parameter int PRESET_SLOTS = cdt_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               in_opcode,
  input  logic [1:0]               in_button,
  input  logic                     cfg_wr_en,
  input  logic [15:0]              cfg_wr_data,
  input  cdt_pkg::dp_cmd_t         cmd,
  output cdt_pkg::dp_status_t      status,
  output logic [cdt_pkg::RES_W-1:0] res_data
);
  import cdt_pkg::*;

  localparam int SLOT_W = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(PRESET_SLOTS - 1);

  logic [6:0]        high_r, high_nxt;
  logic [5:0]        low_r, low_nxt;
  logic              focus_r, focus_nxt;
  logic              play_r, play_nxt;
  logic              paused_r, paused_nxt;
  logic              unit_r, unit_nxt;
  logic              save_r, save_nxt;
  logic              init_r, init_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [15:0]       dflt_r;
  logic [15:0]       store_r [PRESET_SLOTS];
  logic [15:0]       store_nxt [PRESET_SLOTS];

  // payload registers
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic [1:0]        opc_r, btn_r;
  logic              expired_r, expired_nxt;
  logic              leave_r, leave_nxt;
  logic              handled_r, handled_nxt;
  logic [RES_W-1:0]  res_r;

  logic [15:0]       rd;
  logic [15:0]       cur_w;
  logic              roll_match;
  logic              scan_hit;
  logic              is_zero;
  logic              load_en;
  logic [SLOT_W-1:0] next_slot;
  logic [SLOT_W+1:0] slot_ext;

  assign rd        = store_r[ptr_r];
  assign cur_w     = {unit_r, high_r, 2'b00, low_r};
  assign roll_match = (rd[14:0] == cur_w[14:0]);
  assign scan_hit  = (rd == 16'h0000) || (rd == cur_w) || (ptr_r == LAST);
  assign is_zero   = (high_r == 7'd0) && (low_r == 6'd0);
  assign next_slot = (slot_r == LAST) ? '0 : slot_r + 1'b1;
  assign slot_ext  = {2'b00, slot_r};

  assign load_en = (cmd.op == DP_INIT_LOAD) || (cmd.op == DP_EXPIRE) ||
                   (cmd.op == DP_ROLL2) || (cmd.op == DP_BACK_LOAD);

  always_comb begin
    high_nxt    = high_r;
    low_nxt     = low_r;
    focus_nxt   = focus_r;
    play_nxt    = play_r;
    paused_nxt  = paused_r;
    unit_nxt    = unit_r;
    save_nxt    = save_r;
    init_nxt    = init_r;
    slot_nxt    = slot_r;
    ptr_nxt     = ptr_r;
    expired_nxt = expired_r;
    leave_nxt   = leave_r;
    handled_nxt = handled_r;
    store_nxt   = store_r;

    case (cmd.op)
      DP_CAPTURE: begin
        ptr_nxt     = '0;
        expired_nxt = 1'b0;
        leave_nxt   = 1'b0;
        handled_nxt = 1'b1;
      end
      DP_SANITIZE: begin
        if ((rd == 16'h0000) || (rd[7:0] > {2'b00, LOW_MAX})) begin
          store_nxt[ptr_r] = dflt_r;
        end
        ptr_nxt = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;
      end
      DP_INIT_LOAD: begin
        play_nxt   = 1'b1;
        paused_nxt = 1'b1;
        init_nxt   = 1'b1;
      end
      DP_TICK: begin
        if (low_r == 6'd0) begin
          low_nxt  = LOW_MAX;
          high_nxt = (high_r == 7'd0) ? HIGH_MAX : sat_high(high_r - 7'd1);
        end else begin
          low_nxt = sat_low({2'b00, low_r - 6'd1});
        end
      end
      DP_EXPIRE: begin
        paused_nxt  = 1'b1;
        expired_nxt = 1'b1;
      end
      DP_UNHANDLED: handled_nxt = 1'b0;
      DP_EXIT_PLAY: play_nxt = 1'b0;
      DP_STEP_UP: begin
        if (focus_r) begin
          high_nxt = (high_r >= HIGH_MAX) ? 7'd0 : high_r + 7'd1;
        end else begin
          low_nxt = (low_r >= LOW_MAX) ? 6'd0 : low_r + 6'd1;
        end
      end
      DP_STEP_DOWN: begin
        if (focus_r) begin
          high_nxt = (high_r == 7'd0) ? HIGH_MAX : sat_high(high_r - 7'd1);
        end else begin
          low_nxt = (low_r == 6'd0) ? LOW_MAX : sat_low({2'b00, low_r - 6'd1});
        end
      end
      DP_PAUSE: begin
        // pause only acts in play mode; also point the store at the marked slot
        paused_nxt = paused_r | play_r;
        ptr_nxt    = slot_r;
      end
      DP_ROLL1: begin
        if (!roll_match) begin
          high_nxt = sat_high(rd[14:8]);
          low_nxt  = sat_low(rd[7:0]);
        end else begin
          ptr_nxt = next_slot;
        end
      end
      DP_ROLL2: begin
        slot_nxt = ptr_r;
        save_nxt = 1'b1;
      end
      DP_BACK_LOAD:    play_nxt  = 1'b1;
      DP_TOGGLE_FOCUS: focus_nxt = ~focus_r;
      DP_TOGGLE_UNIT:  unit_nxt  = ~unit_r;
      DP_LEAVE:        leave_nxt = 1'b1;
      DP_START: begin
        play_nxt   = 1'b1;
        paused_nxt = 1'b1;
        save_nxt   = 1'b1;
      end
      DP_RESUME: begin
        paused_nxt = 1'b0;
        ptr_nxt    = '0;
      end
      DP_SCAN: begin
        if (!scan_hit) begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      DP_SHIFT: begin
        // move-to-front: entries up to the hit slide down one place
        for (int i = 1; i < PRESET_SLOTS; i++) begin
          if (SLOT_W'(i) <= ptr_r) begin
            store_nxt[i] = store_r[i-1];
          end
        end
        store_nxt[0] = cur_w;
        slot_nxt     = '0;
        save_nxt     = 1'b0;
      end
      default: ;
    endcase

    // preset load; an empty word leaves the unit and counts alone
    if (load_en && (rd != 16'h0000)) begin
      unit_nxt = rd[15];
      high_nxt = sat_high(rd[14:8]);
      low_nxt  = sat_low(rd[7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r   <= '0;
      low_r    <= '0;
      focus_r  <= 1'b0;
      play_r   <= 1'b0;
      paused_r <= 1'b0;
      unit_r   <= 1'b0;
      save_r   <= 1'b0;
      init_r   <= 1'b0;
      slot_r   <= '0;
      dflt_r   <= PRESET_INIT_WORD;
      for (int i = 0; i < PRESET_SLOTS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      high_r   <= high_nxt;
      low_r    <= low_nxt;
      focus_r  <= focus_nxt;
      play_r   <= play_nxt;
      paused_r <= paused_nxt;
      unit_r   <= unit_nxt;
      save_r   <= save_nxt;
      init_r   <= init_nxt;
      slot_r   <= slot_nxt;
      store_r  <= store_nxt;
      if (cfg_wr_en) begin
        dflt_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    expired_r <= expired_nxt;
    leave_r   <= leave_nxt;
    handled_r <= handled_nxt;
    if (cmd.op == DP_CAPTURE) begin
      opc_r <= in_opcode;
      btn_r <= in_button;
    end
    if (cmd.out_load) begin
      res_r <= {handled_r, leave_r, expired_r, slot_ext[1:0], focus_r, ~play_r,
                play_r & ~paused_r, unit_r, low_r, high_r};
    end
  end

  always_comb begin
    status.opcode     = opc_r;
    status.button     = btn_r;
    status.play       = play_r;
    status.paused     = paused_r;
    status.save       = save_r;
    status.init_done  = init_r;
    status.zero       = is_zero;
    status.roll_match = roll_match;
    status.scan_hit   = scan_hit;
    status.ptr_last   = (ptr_r == LAST);
  end

  assign res_data = res_r;

endmodule

// ===== hw/rtl/cdt_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_controller
// Event sequencer: decodes an item and steps the datapath through it.
// ----------------------------------------------------------------------------
module cdt_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  cdt_pkg::dp_status_t status,
  output cdt_pkg::dp_cmd_t    cmd
);
  import cdt_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_resume;
  logic       out_free;

  assign can_resume = status.play && status.paused && !status.zero;
  assign out_free   = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_FIN;
        case (status.opcode)
          OPC_INIT: begin
            if (!status.init_done) begin
              state_nxt = ST_SAN;
            end
          end
          OPC_TICK: begin
            if (status.play && !status.paused) begin
              state_nxt = ST_TICK_CHK;
            end
          end
          OPC_SHORT: begin
            case (status.button)
              BTN_DOWN: begin
                if (status.play) begin
                  state_nxt = ST_ROLL1;
                end
              end
              BTN_SEL: begin
                if (status.play && status.paused) begin
                  state_nxt = ST_RESUME;
                end
              end
              BTN_BACK: begin
                if (!status.play) begin
                  state_nxt = ST_BACK_LOAD;
                end
              end
              default: ;
            endcase
          end
          OPC_LONG: begin
            case (status.button)
              BTN_DOWN: begin
                if (!status.play) begin
                  state_nxt = ST_ROLL1;
                end
              end
              BTN_SEL: begin
                if (!status.play && !status.zero) begin
                  state_nxt = ST_RESUME;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      ST_SAN: begin
        if (status.ptr_last) begin
          state_nxt = ST_INIT_LOAD;
        end
      end
      ST_INIT_LOAD: state_nxt = ST_FIN;
      ST_TICK_CHK:  state_nxt = ST_FIN;
      ST_ROLL1:     state_nxt = status.roll_match ? ST_ROLL2 : ST_FIN;
      ST_ROLL2:     state_nxt = ST_FIN;
      ST_BACK_LOAD: state_nxt = ST_FIN;
      ST_RESUME:    state_nxt = (can_resume && status.save) ? ST_SCAN : ST_FIN;
      ST_SCAN: begin
        if (status.scan_hit) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd.op       = DP_NONE;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.op = DP_CAPTURE;
        end
      end
      ST_DECODE: begin
        case (status.opcode)
          OPC_TICK: begin
            cmd.op = (status.play && !status.paused) ? DP_TICK : DP_UNHANDLED;
          end
          OPC_SHORT: begin
            case (status.button)
              BTN_UP: begin
                if (!status.play) begin
                  cmd.op = DP_STEP_UP;
                end else if (status.paused) begin
                  cmd.op = DP_EXIT_PLAY;
                end
              end
              BTN_DOWN: cmd.op = status.play ? DP_PAUSE : DP_STEP_DOWN;
              BTN_SEL: begin
                if (!status.play) begin
                  cmd.op = DP_TOGGLE_FOCUS;
                end else if (!status.paused) begin
                  cmd.op = DP_PAUSE;
                end
              end
              BTN_BACK: cmd.op = status.play ? DP_LEAVE : DP_PAUSE;
              default: ;
            endcase
          end
          OPC_LONG: begin
            case (status.button)
              BTN_UP: begin
                if (!status.play) begin
                  cmd.op = DP_TOGGLE_UNIT;
                end
              end
              BTN_DOWN: begin
                if (!status.play) begin
                  cmd.op = DP_PAUSE;
                end
              end
              BTN_SEL: begin
                if (!status.play && !status.zero) begin
                  cmd.op = DP_START;
                end
              end
              BTN_BACK: cmd.op = DP_UNHANDLED;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      ST_SAN:       cmd.op = DP_SANITIZE;
      ST_INIT_LOAD: cmd.op = DP_INIT_LOAD;
      ST_TICK_CHK: begin
        if (status.zero) begin
          cmd.op = DP_EXPIRE;
        end
      end
      ST_ROLL1:     cmd.op = DP_ROLL1;
      ST_ROLL2:     cmd.op = DP_ROLL2;
      ST_BACK_LOAD: cmd.op = DP_BACK_LOAD;
      ST_RESUME: begin
        if (can_resume) begin
          cmd.op = DP_RESUME;
        end
      end
      ST_SCAN:  cmd.op = DP_SCAN;
      ST_SHIFT: cmd.op = DP_SHIFT;
      ST_FIN:   cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ===== hw/rtl/countdown_timer_with_presets_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_timer_with_presets_unit
// Event-driven two-field countdown timer with an MRU preset store.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  in_      | slave     | in_tvalid/in_tready   | tdata: button, tuser: opcode
//  out_     | master    | out_tvalid/out_tready | tdata: one result per item
//  cfg_     | write     | cfg_wr_en             | cfg_wr_data: default preset
//
//  Sequence: one item at a time; decode, up to two datapath steps, then the
//  result load, after which the next item is taken. First init walks the
//  store, and a saving start scans it.
//  Reset: rst_n synchronous, active low; clears counts, flags, store, valid.
//  Stalls: the result sits in an output register; the next item is taken
//  while it waits, and a new result waits until that register is free.
// ----------------------------------------------------------------------------
module countdown_timer_with_presets_unit #(
  parameter int PRESET_SLOTS = cdt_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // in_tdata: [1:0] button
  input  logic [cdt_pkg::IN_W-1:0]  in_tdata,
  // in_tuser: [1:0] opcode
  input  logic [cdt_pkg::USR_W-1:0] in_tuser,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // out_tdata: [6:0] count_high, [12:7] count_low, [13] minutes_unit,
  // [14] running, [15] editing, [16] focus_high, [18:17] selected_slot,
  // [19] expired, [20] leave_screen, [21] handled
  output logic [cdt_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data
);
  import cdt_pkg::*;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [RES_W-1:0] res_data;

  // sequencer: one state per kind of datapath step; sanitize and scan repeat as they walk the store
  cdt_controller u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // counts, flags, preset store (one read port via a slot pointer)
  cdt_datapath #(
    .PRESET_SLOTS(PRESET_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_opcode  (in_tuser[1:0]),
    .in_button  (in_tdata[1:0]),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .status     (status),
    .res_data   (res_data)
  );

  // pad the packed result to whole bytes
  assign out_tdata = {{(OUT_W - RES_W){1'b0}}, res_data};

endmodule

// ===== hw/rtl/cdt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_checker
// Port-level checks on the timer's result stream.
// ----------------------------------------------------------------------------
module cdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic [23:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // fields stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:0] <= 7'd99) && (out_tdata[12:7] <= 6'd59))
    else $error("count field out of range");

  // an expiry leaves the timer paused and counts as handled
  a_expire: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |-> !out_tdata[14] && out_tdata[21] &&
                                    !out_tdata[15])
    else $error("expired result inconsistent");

  // editing never runs; leave only from play mode
  a_modes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[15] || out_tdata[20]) |->
      !(out_tdata[15] && out_tdata[14]) && !(out_tdata[15] && out_tdata[20]))
    else $error("mode flags inconsistent");

endmodule

bind countdown_timer_with_presets_unit cdt_checker u_cdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tdata (out_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready)
);
